### rtl/hfsp_pkg.sv
// Shared types, codes and constants of the Hopf flow step projector.
package hfsp_pkg;

  localparam int unsigned CFG_DW = 31;
  localparam int unsigned CFG_IW = 2;

  localparam logic [CFG_IW-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_COS  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_SIN  = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic MODE_HOPF = 1'b0;

  localparam logic [CFG_DW-1:0] COS_RESET = 31'd1073720629;
  localparam logic [CFG_DW-1:0] SIN_RESET = 31'd6746519;

  // 1/K of the unbounded CORDIC in Q1.30, and pi/2 in Q2.29.
  localparam logic [CFG_DW-1:0] INV_GAIN_Q30 = 31'd652032874;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;

  localparam logic signed [31:0] ATAN_HEAD [11] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579, 32'sd33510843,
    32'sd16771758, 32'sd8387925, 32'sd4194219, 32'sd2097141, 32'sd1048575, 32'sd524288
  };

  typedef struct packed {
    logic              opcode;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_w;
  } in_t;

  typedef struct packed {
    logic signed [31:0] proj_first;
    logic signed [31:0] proj_second;
    logic signed [31:0] proj_third;
  } out_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } mac_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROJ,
    ST_MAC,
    ST_RND,
    ST_CORD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_STEP,
    PH_HOPF,
    PH_MAG
  } phase_e;

  // Arctangent of 2^-i in Q2.29.
  function automatic logic signed [31:0] atan_entry(input logic [7:0] i);
    if (i < 8'd11) begin
      return ATAN_HEAD[i[3:0]];
    end else if (i <= 8'd29) begin
      return $signed(32'(1) << (8'd29 - i));
    end else begin
      return '0;
    end
  endfunction

endpackage

### rtl/hopf_flow_step_projector.sv
// Top level of the Hopf flow step projector: sequencer, point store and config.
//
// The block holds a point (x,y,z,w) on the unit 3-sphere with DATA_WIDTH-2
// fraction bits. A load beat sets the point from four Q1.30 values; a step beat
// moves it once along the Hopf field (-y,x,-w,z) with the cosine and sine
// coefficients. Each input beat yields exactly one output beat: in mode 0 the
// Hopf map to the 2-sphere, in mode 1 three hyperspherical angles from chained
// CORDIC vectorings, all in Q2.29 and the Hopf map with saturation. Every
// product goes through one shared multiply-accumulate unit that consumes one
// 16-bit digit per cycle (N = 2 digits up to a width of 32 bits, one more for
// each further 16 bits), and the angles come from one CORDIC unit doing one
// micro-rotation per cycle. A step beat runs the step and then the projection;
// a load beat runs only the projection. The input is not ready while an item
// is being worked on; a finished result waits in the output register and the
// next item may be accepted meanwhile. Configuration is written through a
// plain write port; the user must write it only while the block is idle, as
// the block itself does not enforce this.
module hopf_flow_step_projector #(
  parameter int unsigned DATA_WIDTH        = 32,
  parameter int unsigned CORDIC_ITERATIONS = 30
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hfsp_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [hfsp_pkg::CFG_DW-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hfsp_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hfsp_pkg::out_t                 out_data_o
);

  localparam int unsigned DW       = DATA_WIDTH;
  localparam int          FRAC     = DW - 2;
  localparam int unsigned AW       = DW + 4;
  localparam int unsigned BW       = (DW > 32) ? DW : 32;
  localparam int unsigned NCH      = (BW + 15) / 16;
  localparam int unsigned CIW      = $clog2(NCH);
  localparam int unsigned ACCW     = AW + 16 * NCH + 5;
  localparam int          SH_LOAD  = 30 - FRAC;
  localparam int          SH_STEP  = 30;
  localparam int          SH_HOPF  = 2 * FRAC - 30;
  localparam int          SH_HOPF3 = 2 * FRAC - 29;
  localparam int          SH_MAG   = 30;

  // Rescale by 2^-sh with the half LSB added first; a negative sh scales up.
  function automatic logic signed [ACCW-1:0] rscale(input logic signed [ACCW-1:0] v,
                                                    input int sh);
    logic signed [ACCW-1:0] half;
    logic signed [ACCW-1:0] r;
    half = '0;
    r    = v;
    if (sh > 0) begin
      half = ACCW'(1) << (sh - 1);
      r    = (v + half) >>> sh;
    end else if (sh < 0) begin
      r = v <<< (-sh);
    end
    return r;
  endfunction

  function automatic logic signed [ACCW-1:0] sat(input logic signed [ACCW-1:0] v,
                                                 input int w);
    logic signed [ACCW-1:0] maxv;
    logic signed [ACCW-1:0] minv;
    maxv = (ACCW'(1) << (w - 1)) - ACCW'(1);
    minv = -maxv - ACCW'(1);
    if (v > maxv) begin
      return maxv;
    end else if (v < minv) begin
      return minv;
    end
    return v;
  endfunction

  hfsp_pkg::state_e state_q, state_d;
  hfsp_pkg::phase_e phase_q;

  logic [1:0]              r_q, t_q, v_q, t_last;
  logic [CIW-1:0]          k_q;
  logic                    k_end, t_end, out_free, accept;
  logic signed [DW-1:0]    pt_q  [4];
  logic signed [DW-1:0]    nxt_q [3];
  logic signed [31:0]      res_q [3];
  logic                    mode_q;
  logic [hfsp_pkg::CFG_DW-1:0] cos_q, sin_q;
  hfsp_pkg::out_t          out_q;
  logic                    out_valid_q;

  hfsp_pkg::mac_ctrl_t     mac_ctrl;
  logic                    mac_neg;
  logic [1:0]              a_idx, b_idx;
  logic signed [AW-1:0]    a_op;
  logic signed [BW-1:0]    b_op;
  logic signed [ACCW-1:0]  acc;
  logic signed [ACCW-1:0]  rnd_step, rnd_hopf, rnd_mag;
  logic signed [DW-1:0]    load_pt [4];

  logic                    cdc_start, cdc_done;
  logic signed [AW-1:0]    cdc_x, cdc_y, cdc_mag;
  logic signed [31:0]      cdc_ang;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign k_end    = (k_q == CIW'(NCH - 1));
  assign t_end    = (t_q == t_last);

  // Number of product terms minus one for the current result.
  always_comb begin
    case (phase_q)
      hfsp_pkg::PH_STEP: t_last = 2'd1;
      hfsp_pkg::PH_HOPF: t_last = (r_q == 2'd2) ? 2'd3 : 2'd1;
      default:           t_last = 2'd0;
    endcase
  end

  // Operand selection. In a step, the field term pairs x with y and z with w,
  // and carries a minus sign for the x and z components.
  always_comb begin
    a_idx   = r_q;
    b_idx   = r_q;
    mac_neg = 1'b0;
    case (phase_q)
      hfsp_pkg::PH_STEP: begin
        a_idx   = (t_q == 2'd0) ? r_q : (r_q ^ 2'd1);
        mac_neg = (t_q == 2'd1) && !r_q[0];
      end
      hfsp_pkg::PH_HOPF: begin
        case ({r_q, t_q})
          4'b00_00: begin a_idx = 2'd0; b_idx = 2'd2; end
          4'b00_01: begin a_idx = 2'd1; b_idx = 2'd3; end
          4'b01_00: begin a_idx = 2'd1; b_idx = 2'd2; end
          4'b01_01: begin a_idx = 2'd0; b_idx = 2'd3; mac_neg = 1'b1; end
          default: begin
            a_idx   = t_q;
            b_idx   = t_q;
            mac_neg = t_q[1];
          end
        endcase
      end
      default: ;
    endcase

    if (phase_q == hfsp_pkg::PH_MAG) begin
      a_op = cdc_mag;
      b_op = $signed(BW'(hfsp_pkg::INV_GAIN_Q30));
    end else if (phase_q == hfsp_pkg::PH_STEP) begin
      a_op = AW'(pt_q[a_idx]);
      b_op = $signed(BW'((t_q == 2'd0) ? cos_q : sin_q));
    end else begin
      a_op = AW'(pt_q[a_idx]);
      b_op = BW'(pt_q[b_idx]);
    end
  end

  always_comb begin
    rnd_step = sat(rscale(acc, SH_STEP), DW);
    rnd_hopf = sat(rscale(acc, (r_q == 2'd2) ? SH_HOPF3 : SH_HOPF), 32);
    rnd_mag  = rscale(acc, SH_MAG);
    load_pt[0] = DW'(sat(rscale(ACCW'(in_data_i.start_x), SH_LOAD), DW));
    load_pt[1] = DW'(sat(rscale(ACCW'(in_data_i.start_y), SH_LOAD), DW));
    load_pt[2] = DW'(sat(rscale(ACCW'(in_data_i.start_z), SH_LOAD), DW));
    load_pt[3] = DW'(sat(rscale(ACCW'(in_data_i.start_w), SH_LOAD), DW));
  end

  // The first vectoring takes (z, w); the later ones take the previous
  // magnitude straight from the rounding stage.
  always_comb begin
    case (v_q)
      2'd0:    cdc_x = AW'(pt_q[2]);
      2'd1:    cdc_x = AW'(pt_q[1]);
      default: cdc_x = AW'(pt_q[0]);
    endcase
    cdc_y = (v_q == 2'd0) ? AW'(pt_q[3]) : AW'(rnd_mag);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hfsp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_data_i.opcode == hfsp_pkg::OP_LOAD) ? hfsp_pkg::ST_PROJ
                                                            : hfsp_pkg::ST_MAC;
        end
      end
      hfsp_pkg::ST_PROJ: begin
        state_d = (mode_q == hfsp_pkg::MODE_HOPF) ? hfsp_pkg::ST_MAC : hfsp_pkg::ST_CORD;
      end
      hfsp_pkg::ST_MAC: begin
        if (k_end && t_end) begin
          state_d = hfsp_pkg::ST_RND;
        end
      end
      hfsp_pkg::ST_RND: begin
        case (phase_q)
          hfsp_pkg::PH_STEP:
            state_d = (r_q == 2'd3) ? hfsp_pkg::ST_PROJ : hfsp_pkg::ST_MAC;
          hfsp_pkg::PH_HOPF:
            state_d = (r_q == 2'd2) ? hfsp_pkg::ST_OUT : hfsp_pkg::ST_MAC;
          default:
            state_d = hfsp_pkg::ST_CORD;
        endcase
      end
      hfsp_pkg::ST_CORD: begin
        if (cdc_done) begin
          state_d = (v_q == 2'd2) ? hfsp_pkg::ST_OUT : hfsp_pkg::ST_MAC;
        end
      end
      hfsp_pkg::ST_OUT: begin
        if (out_free) begin
          state_d = hfsp_pkg::ST_IDLE;
        end
      end
      default: state_d = hfsp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_ready_o   = (state_q == hfsp_pkg::ST_IDLE);
    mac_ctrl.en  = (state_q == hfsp_pkg::ST_MAC);
    mac_ctrl.clr = (t_q == 2'd0) && (k_q == '0);
    mac_ctrl.neg = mac_neg;
    cdc_start    = ((state_q == hfsp_pkg::ST_PROJ) && (mode_q != hfsp_pkg::MODE_HOPF)) ||
                   ((state_q == hfsp_pkg::ST_RND) && (phase_q == hfsp_pkg::PH_MAG));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hfsp_pkg::ST_IDLE;
      phase_q     <= hfsp_pkg::PH_STEP;
      r_q         <= '0;
      t_q         <= '0;
      k_q         <= '0;
      v_q         <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= hfsp_pkg::MODE_HOPF;
      cos_q       <= hfsp_pkg::COS_RESET;
      sin_q       <= hfsp_pkg::SIN_RESET;
      for (int i = 0; i < 4; i++) begin
        pt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          hfsp_pkg::REG_MODE: mode_q <= cfg_data_i[0];
          hfsp_pkg::REG_COS:  cos_q  <= cfg_data_i;
          hfsp_pkg::REG_SIN:  sin_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (state_q == hfsp_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        hfsp_pkg::ST_IDLE: begin
          if (accept) begin
            phase_q <= hfsp_pkg::PH_STEP;
            r_q     <= '0;
            t_q     <= '0;
            k_q     <= '0;
            v_q     <= '0;
            if (in_data_i.opcode == hfsp_pkg::OP_LOAD) begin
              for (int i = 0; i < 4; i++) begin
                pt_q[i] <= load_pt[i];
              end
            end
          end
        end
        hfsp_pkg::ST_PROJ: begin
          phase_q <= (mode_q == hfsp_pkg::MODE_HOPF) ? hfsp_pkg::PH_HOPF : hfsp_pkg::PH_MAG;
          r_q     <= '0;
          t_q     <= '0;
          k_q     <= '0;
        end
        hfsp_pkg::ST_MAC: begin
          if (k_end) begin
            k_q <= '0;
            t_q <= t_end ? 2'd0 : t_q + 2'd1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        hfsp_pkg::ST_RND: begin
          if (phase_q != hfsp_pkg::PH_MAG) begin
            r_q <= r_q + 2'd1;
          end
          // The new point is only committed once all four components are known.
          if (phase_q == hfsp_pkg::PH_STEP && r_q == 2'd3) begin
            pt_q[0] <= nxt_q[0];
            pt_q[1] <= nxt_q[1];
            pt_q[2] <= nxt_q[2];
            pt_q[3] <= DW'(rnd_step);
          end
        end
        hfsp_pkg::ST_CORD: begin
          if (cdc_done) begin
            v_q <= v_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == hfsp_pkg::ST_RND) begin
      if (phase_q == hfsp_pkg::PH_STEP && r_q != 2'd3) begin
        nxt_q[r_q] <= DW'(rnd_step);
      end
      if (phase_q == hfsp_pkg::PH_HOPF && r_q != 2'd3) begin
        res_q[r_q] <= 32'(rnd_hopf);
      end
    end
    if (state_q == hfsp_pkg::ST_CORD && cdc_done && v_q != 2'd3) begin
      res_q[2'd2 - v_q] <= cdc_ang;
    end
    if (state_q == hfsp_pkg::ST_OUT && out_free) begin
      out_q.proj_first  <= res_q[0];
      out_q.proj_second <= res_q[1];
      out_q.proj_third  <= res_q[2];
    end
  end

  hfsp_mac #(
    .AW   (AW),
    .BW   (BW),
    .NCH  (NCH),
    .CIW  (CIW),
    .ACCW (ACCW)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mac_ctrl),
    .chunk_i (k_q),
    .a_i     (a_op),
    .b_i     (b_op),
    .acc_o   (acc)
  );

  hfsp_cordic #(
    .CW   (AW),
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cdc_start),
    .x_i     (cdc_x),
    .y_i     (cdc_y),
    .done_o  (cdc_done),
    .ang_o   (cdc_ang),
    .mag_o   (cdc_mag)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Once a beat is taken the block is busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("input ready directly after an accepted beat");

  // The CORDIC unit only finishes while the sequencer waits for it.
  a_cordic_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdc_done |-> (state_q == hfsp_pkg::ST_CORD))
    else $error("CORDIC finished outside its wait state");

  // A magnitude correction is a single product term.
  a_mag_one_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hfsp_pkg::ST_MAC && phase_q == hfsp_pkg::PH_MAG) |-> (t_q == 2'd0))
    else $error("magnitude correction ran past one term");

  // Leaving the output state always presents a result and frees the input.
  a_out_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hfsp_pkg::ST_OUT && out_free) |=> (out_valid_o && in_ready_o))
    else $error("result not presented when leaving the output state");
`endif

endmodule

### rtl/hfsp_mac.sv
// Shared multiply-accumulate unit, one 16-bit digit of the second operand per enabled cycle.
module hfsp_mac #(
  parameter int unsigned AW   = 36,
  parameter int unsigned BW   = 32,
  parameter int unsigned NCH  = 2,
  parameter int unsigned CIW  = 1,
  parameter int unsigned ACCW = 73
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  hfsp_pkg::mac_ctrl_t     ctrl_i,
  input  logic [CIW-1:0]          chunk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [ACCW-1:0]  acc_o
);

  localparam int unsigned XW = NCH * 16;

  logic signed [XW-1:0]     bx;
  logic signed [16:0]       digit;
  logic signed [AW+16:0]    prod;
  logic signed [ACCW-1:0]   term;
  logic signed [ACCW-1:0]   base;
  logic signed [ACCW-1:0]   acc_d, acc_q;

  // The top digit carries the sign; the lower ones are unsigned.
  always_comb begin
    bx = XW'(b_i);
    if (chunk_i == CIW'(NCH - 1)) begin
      digit = 17'($signed(bx[XW-1 -: 16]));
    end else begin
      digit = $signed({1'b0, bx[16*chunk_i +: 16]});
    end
    prod  = AW'(a_i) * digit;
    term  = ACCW'(prod) <<< (16 * chunk_i);
    base  = ctrl_i.clr ? '0 : acc_q;
    acc_d = ctrl_i.neg ? base - term : base + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### rtl/hfsp_cordic.sv
// CORDIC vectoring unit, one micro-rotation per cycle.
module hfsp_cordic #(
  parameter int unsigned CW   = 36,
  parameter int unsigned ITER = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [CW-1:0]  x_i,
  input  logic signed [CW-1:0]  y_i,
  output logic                  done_o,
  output logic signed [31:0]    ang_o,
  output logic signed [CW-1:0]  mag_o
);

  localparam int unsigned IW = $clog2(ITER + 1);

  logic                 run_q, done_q, zero_q;
  logic [IW-1:0]        it_q;
  logic signed [CW-1:0] xv_q, yv_q;
  logic signed [31:0]   ang_q;
  logic signed [CW-1:0] x0, y0, dx, dy;
  logic signed [31:0]   a0, at;

  // A vector in the left half plane is first turned by a quarter turn.
  always_comb begin
    x0 = x_i;
    y0 = y_i;
    a0 = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0 = y_i;
        y0 = -x_i;
        a0 = hfsp_pkg::HALF_PI_Q29;
      end else begin
        x0 = -y_i;
        y0 = x_i;
        a0 = -hfsp_pkg::HALF_PI_Q29;
      end
    end
    dx = yv_q >>> it_q;
    dy = xv_q >>> it_q;
    at = hfsp_pkg::atan_entry(8'(it_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        it_q  <= '0;
      end else if (run_q) begin
        it_q <= it_q + 1'b1;
        if (it_q == IW'(ITER - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xv_q   <= x0;
      yv_q   <= y0;
      ang_q  <= a0;
      zero_q <= (x_i == 0) && (y_i == 0);
    end else if (run_q) begin
      if (yv_q >= 0) begin
        xv_q  <= xv_q + dx;
        yv_q  <= yv_q - dy;
        ang_q <= ang_q + at;
      end else begin
        xv_q  <= xv_q - dx;
        yv_q  <= yv_q + dy;
        ang_q <= ang_q - at;
      end
    end
  end

  assign done_o = done_q;
  assign ang_o  = zero_q ? '0 : ang_q;
  assign mag_o  = xv_q;

endmodule
